// File: rtl/bmcd_pkg.sv
`timescale 1ns / 1ps

package bmcd_pkg;

   // Configuration register file
   localparam int CFG_W = 13;
   localparam int CFG_INDEX_W = 2;
   localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LEVEL  = 2'd2;
   localparam logic [CFG_W-1:0] CFG_RESET_SIZE = 13'd4096;

   // Line store entry: bit 0 newest complete row, bit 1 the row above it
   localparam int STORE_W = 2;

   // Control carried from the read stage to the evaluate stage
   typedef struct packed {
      logic result;    // transaction produces a result
      logic flush;     // flush step, no store write
      logic row0;      // first row, store only
      logic up_ok;     // upper neighbor lies inside the image
      logic left_ok;   // left neighbor lies inside the image
      logic right_ok;  // right neighbor lies inside the image
      logic last;      // final output pixel of the frame
      logic fwd_a;     // center read hits the write in flight
      logic fwd_b;     // right read hits the write in flight
   } stage_ctrl_type;

   // One queued result
   typedef struct packed {
      logic mask_bit;
      logic frame_end;
   } rsp_entry_type;

endpackage

// File: rtl/bmcd_ram.sv
`timescale 1ns / 1ps

module bmcd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write one entry, read two; a read of the written entry returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/binary_mask_cross_dilation.sv
`timescale 1ns / 1ps

// Cross-shaped binary dilation of a raster mask, one pixel per transaction.
// Input channel req_*: req_command 0 carries a mask pixel in req_pixel_bit,
// req_command 1 is a flush step that emits one pixel of the last row.
// Result channel rsp_*: rsp_mask_bit is the dilated pixel, rsp_frame_end marks
// the final pixel of the frame. Results lag by one row: the pixel of row r+1
// at column c releases the result of row r at column c. First-row pixels and
// flush steps sent before the whole frame has arrived give no result.
// Configuration port csr_*: image width, image height and match level, written
// only while the block is idle; the user must see to this, the block does not enforce it.
// Throughput: one transaction per cycle while req_ready is high, set by the
// single line-store pass (two reads and one write per cycle). A result goes
// through store read and evaluate, then the output queue, before rsp_valid.
// Reset clears counters and the output queue and restores the configuration
// to 4096 x 4096 with match level 0; the line store is not cleared and needs
// no clearing pass. Results queue in two output slots; req_ready drops when the
// queued results plus the one being pushed would fill both slots.
module binary_mask_cross_dilation import bmcd_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic                   req_pixel_bit,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_mask_bit,
   output logic                   rsp_frame_end,
   input  logic                   csr_write_en,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   function automatic logic hit(input logic b, input logic lvl);
      return b == lvl;
   endfunction

   // Configuration
   logic [CFG_W-1:0] width_cfg_ff;
   logic [CFG_W-1:0] height_cfg_ff;
   logic             match_ff;
   logic [31:0]      width_sat;
   logic [31:0]      height_sat;
   logic [WW-1:0]    eff_width;
   logic [RW-1:0]    eff_height;

   // Counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;

   // Read stage
   logic           accept;
   logic           pix_go;
   logic           flush_go;
   logic [CW-1:0]  col_sel;
   logic [CW-1:0]  col_next;
   logic           col_last;
   logic           row_open;
   stage_ctrl_type ctrl_in;

   // Evaluate stage
   logic               s1_valid_ff;
   stage_ctrl_type     s1_ctrl_ff;
   logic [CW-1:0]      s1_col_ff;
   logic               s1_pix_ff;
   logic [STORE_W-1:0] s1_fwd_data_ff;
   logic               left_ff;
   logic [STORE_W-1:0] ram_a;
   logic [STORE_W-1:0] ram_b;
   logic [STORE_W-1:0] entry_a;
   logic [STORE_W-1:0] entry_b;
   logic               wr_en;
   logic [STORE_W-1:0] wr_data;
   logic               mask;
   logic               push;
   rsp_entry_type      new_entry;

   // Output queue
   logic [1:0]    q_count_ff, q_count_in;
   rsp_entry_type q0_ff, q0_in;
   rsp_entry_type q1_ff, q1_in;
   logic          pop;
   logic [1:0]    slot;
   logic [2:0]    inflight;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_RESET_SIZE;
         height_cfg_ff <= CFG_RESET_SIZE;
         match_ff      <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_cfg_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_cfg_ff <= csr_wdata;
            REG_MATCH_LEVEL:  match_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Saturate the frame size into the supported range
   always_comb begin
      if (width_cfg_ff == '0) begin
         width_sat = 32'd1;
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         width_sat = 32'(MAX_WIDTH);
      end else begin
         width_sat = 32'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         height_sat = 32'd1;
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         height_sat = 32'(MAX_HEIGHT);
      end else begin
         height_sat = 32'(height_cfg_ff);
      end
   end

   assign eff_width  = WW'(width_sat);
   assign eff_height = RW'(height_sat);

   // Decode the incoming transaction
   assign accept   = req_valid && req_ready;
   assign col_sel  = req_command ? out_col_ff : in_col_ff;
   assign col_next = col_sel + CW'(1);
   assign col_last = (32'(col_sel) + 32'd1) >= 32'(eff_width);
   assign row_open = 32'(in_row_ff) < 32'(eff_height);
   assign pix_go   = accept && !req_command && row_open;
   assign flush_go = accept && req_command && !row_open;

   // Advance column and row counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      if (pix_go) begin
         if (col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = col_next;
         end
      end
      if (flush_go) begin
         if (col_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
         end else begin
            out_col_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // Build control for the evaluate stage
   always_comb begin
      ctrl_in.result   = flush_go || (pix_go && (in_row_ff != '0));
      ctrl_in.flush    = req_command;
      ctrl_in.row0     = in_row_ff == '0;
      ctrl_in.up_ok    = req_command ? (32'(eff_height) >= 32'd2)
                                     : (32'(in_row_ff) >= 32'd2);
      ctrl_in.left_ok  = col_sel != '0;
      ctrl_in.right_ok = !col_last;
      ctrl_in.last     = req_command && col_last;
      ctrl_in.fwd_a    = wr_en && (s1_col_ff == col_sel);
      ctrl_in.fwd_b    = wr_en && (s1_col_ff == col_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pix_go || flush_go;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff     <= ctrl_in;
      s1_col_ff      <= col_sel;
      s1_pix_ff      <= req_pixel_bit;
      s1_fwd_data_ff <= wr_data;
   end

   // Line store: read center and right entries, write back the center entry
   bmcd_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (s1_col_ff),
      .wr_data   (wr_data),
      .rd_addr_a (col_sel),
      .rd_data_a (ram_a),
      .rd_addr_b (col_next),
      .rd_data_b (ram_b)
   );

   // Forward the write that was in flight during the read
   assign entry_a = s1_ctrl_ff.fwd_a ? s1_fwd_data_ff : ram_a;
   assign entry_b = s1_ctrl_ff.fwd_b ? s1_fwd_data_ff : ram_b;

   // Shift the column: the older row moves up, the new pixel enters
   assign wr_en   = s1_valid_ff && !s1_ctrl_ff.flush;
   assign wr_data = s1_ctrl_ff.row0 ? {1'b0, s1_pix_ff} : {entry_a[0], s1_pix_ff};

   // Evaluate the cross neighborhood
   always_comb begin
      mask = hit(entry_a[0], match_ff)
           | (s1_ctrl_ff.up_ok && hit(entry_a[1], match_ff))
           | (!s1_ctrl_ff.flush && hit(s1_pix_ff, match_ff))
           | (s1_ctrl_ff.left_ok && hit(left_ff, match_ff))
           | (s1_ctrl_ff.right_ok && hit(entry_b[0], match_ff));
   end

   // Keep the center pixel as the next column's left neighbor
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         left_ff <= entry_a[0];
      end
   end

   assign push                = s1_valid_ff && s1_ctrl_ff.result;
   assign new_entry.mask_bit  = mask;
   assign new_entry.frame_end = s1_ctrl_ff.last;

   // Two-slot output queue
   assign pop  = (q_count_ff != 2'd0) && rsp_ready;
   assign slot = q_count_ff - {1'b0, pop};

   always_comb begin
      q0_in      = q0_ff;
      q1_in      = q1_ff;
      q_count_in = q_count_ff - {1'b0, pop} + {1'b0, push};
      if (pop) begin
         q0_in = q1_ff;
      end
      if (push) begin
         if (slot == 2'd0) begin
            q0_in = new_entry;
         end else begin
            q1_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= 2'd0;
      end else begin
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   // Accept while the queue can absorb every result in flight
   assign inflight  = {1'b0, q_count_ff} + {2'b0, push} - {2'b0, pop};
   assign req_ready = inflight <= 3'd1;

   assign rsp_valid     = q_count_ff != 2'd0;
   assign rsp_mask_bit  = q0_ff.mask_bit;
   assign rsp_frame_end = q0_ff.frame_end;

endmodule

// File: rtl/bmcd_checker.sv
`timescale 1ns / 1ps

module bmcd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_mask_bit,
   input logic rsp_frame_end
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mask_bit)
                                 && $stable(rsp_frame_end))
      else $error("stalled result changed or dropped");

   // Drop the result channel at reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stall input only while a result waits
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // Raise a result only after an accepted transaction has passed evaluate and the queue
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a releasing transaction");

endmodule

bind binary_mask_cross_dilation bmcd_checker u_checker (.*);
